// File: rtl/itoa_pkg.sv
// shared types and constants of the integer to ascii converter
package itoa_pkg;

  localparam int unsigned MAX_CHARS = 64;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam int unsigned LEN_W     = $clog2(MAX_CHARS + 1);

  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned DD_BITS    = 4;
  localparam int unsigned DD_CYCLES  = VAL_W / DD_BITS;
  localparam int unsigned DD_CNT_W   = $clog2(DD_CYCLES);

  localparam int unsigned PTR_DIGITS = 12;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_DEC    = 3'd0;
  localparam logic [2:0] KIND_BIN    = 3'd1;
  localparam logic [2:0] KIND_OCT    = 3'd2;
  localparam logic [2:0] KIND_HEX_UP = 3'd3;
  localparam logic [2:0] KIND_HEX_LO = 3'd4;
  localparam logic [2:0] KIND_PTR_UP = 3'd5;
  localparam logic [2:0] KIND_PTR_LO = 3'd6;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_BIN,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
    radix_e           radix;
    logic             upper;
    logic             ptr;
  } job_t;

endpackage

// File: rtl/itoa_front.sv
// front end: accepts input transactions and classifies them into jobs
module itoa_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [itoa_pkg::VAL_W-1:0]  value_i,
  input  logic                        is_signed_i,
  input  logic [2:0]                  kind_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output itoa_pkg::job_t              q_job_o
);

  logic             ptr;
  logic             upper;
  logic             neg;
  itoa_pkg::radix_e radix;

  always_comb begin
    ptr   = (kind_i == itoa_pkg::KIND_PTR_UP) || (kind_i == itoa_pkg::KIND_PTR_LO);
    upper = (kind_i == itoa_pkg::KIND_PTR_UP) || (kind_i == itoa_pkg::KIND_HEX_UP);
    neg   = !ptr && is_signed_i && value_i[itoa_pkg::VAL_W-1];
    unique case (kind_i)
      itoa_pkg::KIND_BIN:    radix = itoa_pkg::RADIX_BIN;
      itoa_pkg::KIND_OCT:    radix = itoa_pkg::RADIX_OCT;
      itoa_pkg::KIND_HEX_UP,
      itoa_pkg::KIND_HEX_LO,
      itoa_pkg::KIND_PTR_UP,
      itoa_pkg::KIND_PTR_LO: radix = itoa_pkg::RADIX_HEX;
      default:               radix = itoa_pkg::RADIX_DEC;
    endcase
  end

  assign q_job_o.mag   = neg ? (~value_i + itoa_pkg::VAL_W'(1)) : value_i;
  assign q_job_o.neg   = neg;
  assign q_job_o.radix = radix;
  assign q_job_o.upper = upper;
  assign q_job_o.ptr   = ptr;

  assign q_push_o   = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

endmodule

// File: rtl/itoa_fifo.sv
// short job queue between front end and back end
module itoa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itoa_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output itoa_pkg::job_t job_o
);

  itoa_pkg::job_t                    mem_q [itoa_pkg::QDEPTH];
  logic [itoa_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [itoa_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [itoa_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push;
  logic                              do_pop;

  assign full_o  = (cnt_q == itoa_pkg::QCNT_W'(itoa_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ? '0
               : wr_ptr_q + itoa_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ? '0
               : rd_ptr_q + itoa_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + itoa_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - itoa_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/itoa_back.sv
// back end: digit generation into a character stack, then output in order
module itoa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  itoa_pkg::job_t              q_job_i,
  output logic                        q_pop_o,
  input  logic [itoa_pkg::LEN_W-1:0]  cap_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  character_o,
  output logic                        last_o
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_GEN,
    ST_PAD,
    ST_PFX_X,
    ST_PFX_0,
    ST_SIGN,
    ST_EMIT
  } state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      return CH_ZERO + {4'h0, d};
    end
    return base + {4'h0, d} - 8'd10;
  endfunction

  // double dabble over DD_BITS (four) input bits
  function automatic logic [itoa_pkg::BCD_W-1:0] dd_step(
    input logic [itoa_pkg::BCD_W-1:0]   bcd_in,
    input logic [itoa_pkg::DD_BITS-1:0] bits
  );
    logic [itoa_pkg::BCD_W-1:0] b;
    b = bcd_in;
    for (int s = 0; s < itoa_pkg::DD_BITS; s++) begin
      for (int g = 0; g < itoa_pkg::BCD_DIGITS; g++) begin
        if (b[4*g +: 4] >= 4'd5) begin
          b[4*g +: 4] = b[4*g +: 4] + 4'd3;
        end
      end
      b = {b[itoa_pkg::BCD_W-2:0], bits[itoa_pkg::DD_BITS-1-s]};
    end
    return b;
  endfunction

  state_e                           state_q, state_d;
  logic [itoa_pkg::LEN_W-1:0]       len_q, len_d;
  logic                             out_valid_q, out_valid_d;
  logic [7:0]                       char_q, char_d;
  logic                             last_q, last_d;

  logic [itoa_pkg::BCD_W-1:0]       work_q, work_d;
  logic [itoa_pkg::VAL_W-1:0]       bin_q, bin_d;
  logic [itoa_pkg::DD_CNT_W-1:0]    dd_cnt_q, dd_cnt_d;
  itoa_pkg::radix_e                 radix_q, radix_d;
  logic                             upper_q, upper_d;
  logic                             ptr_q, ptr_d;
  logic                             neg_q, neg_d;
  logic [7:0]                       stack_q [itoa_pkg::MAX_CHARS];

  logic                             take;
  logic                             push_req;
  logic                             push;
  logic [7:0]                       push_ch;
  logic                             load;
  logic [3:0]                       digit;
  logic [itoa_pkg::BCD_W-1:0]       rest;

  always_comb begin
    unique case (radix_q)
      itoa_pkg::RADIX_BIN: begin
        digit = {3'b000, work_q[0]};
        rest  = work_q >> 1;
      end
      itoa_pkg::RADIX_OCT: begin
        digit = {1'b0, work_q[2:0]};
        rest  = work_q >> 3;
      end
      default: begin
        digit = work_q[3:0];
        rest  = work_q >> 4;
      end
    endcase
  end

  assign take    = (state_q == ST_IDLE) && !q_empty_i;
  assign q_pop_o = take;
  assign load    = (state_q == ST_EMIT) && (len_q != '0) && (!out_valid_q || !out_stall_i);
  assign push    = push_req && (len_q < cap_i);

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    bin_d       = bin_q;
    dd_cnt_d    = dd_cnt_q;
    radix_d     = radix_q;
    upper_d     = upper_q;
    ptr_d       = ptr_q;
    neg_d       = neg_q;
    push_req    = 1'b0;
    push_ch     = CH_ZERO;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          radix_d = q_job_i.radix;
          upper_d = q_job_i.upper;
          ptr_d   = q_job_i.ptr;
          neg_d   = q_job_i.neg;
          if (q_job_i.radix == itoa_pkg::RADIX_DEC) begin
            bin_d    = q_job_i.mag;
            work_d   = '0;
            dd_cnt_d = '0;
            state_d  = ST_CONV;
          end else begin
            work_d  = itoa_pkg::BCD_W'(q_job_i.mag);
            state_d = ST_GEN;
          end
        end
      end
      ST_CONV: begin
        work_d   = dd_step(work_q, bin_q[itoa_pkg::VAL_W-1 -: itoa_pkg::DD_BITS]);
        bin_d    = bin_q << itoa_pkg::DD_BITS;
        dd_cnt_d = dd_cnt_q + itoa_pkg::DD_CNT_W'(1);
        if (dd_cnt_q == itoa_pkg::DD_CNT_W'(itoa_pkg::DD_CYCLES - 1)) begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        push_req = 1'b1;
        push_ch  = digit_char(digit, upper_q);
        work_d   = rest;
        if (rest == '0) begin
          if (ptr_q) begin
            state_d = ST_PAD;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_PAD: begin
        if ((len_q < itoa_pkg::LEN_W'(itoa_pkg::PTR_DIGITS)) && (len_q < cap_i)) begin
          push_req = 1'b1;
          push_ch  = CH_ZERO;
        end else begin
          state_d = ST_PFX_X;
        end
      end
      ST_PFX_X: begin
        push_req = 1'b1;
        push_ch  = upper_q ? CH_X_UP : CH_X_LO;
        state_d  = ST_PFX_0;
      end
      ST_PFX_0: begin
        push_req = 1'b1;
        push_ch  = CH_ZERO;
        state_d  = ST_EMIT;
      end
      ST_SIGN: begin
        push_req = 1'b1;
        push_ch  = CH_MINUS;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          char_d      = stack_q[0];
          last_d      = (len_q == itoa_pkg::LEN_W'(1));
          out_valid_d = 1'b1;
        end
        if ((len_q == '0) || (load && (len_q == itoa_pkg::LEN_W'(1)))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    len_d = len_q;
    if (push) begin
      len_d = len_q + itoa_pkg::LEN_W'(1);
    end else if (load) begin
      len_d = len_q - itoa_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    bin_q    <= bin_d;
    dd_cnt_q <= dd_cnt_d;
    radix_q  <= radix_d;
    upper_q  <= upper_d;
    ptr_q    <= ptr_d;
    neg_q    <= neg_d;
  end

  // character stack, top at entry zero
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= push_ch;
      for (int i = 1; i < itoa_pkg::MAX_CHARS; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (load) begin
      for (int i = 0; i < itoa_pkg::MAX_CHARS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= itoa_pkg::LEN_W'(itoa_pkg::MAX_CHARS))
    else $error("character count beyond stack depth");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (len_q == itoa_pkg::LEN_W'(1))) |=> (len_q == '0))
    else $error("stack not empty after last character");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && load))
    else $error("stack push and pop in the same cycle");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q != ST_IDLE))
    else $error("job taken but back end stayed idle");

endmodule

// File: rtl/integer_to_ascii_radix_core.sv
// top level of the integer to ascii converter
// usage:
//   input channel: value_i, is_signed_i and kind_i move in one transaction when
//   in_valid_i is high and in_stall_o is low. kinds: decimal, binary, octal,
//   hex upper/lower, pointer upper/lower (at least 12 hex digits, 0X/0x prefix).
//   output channel: one ascii character per transaction on character_o, most
//   significant first, last_o set on the final one; taken when out_valid_o is
//   high and out_stall_i is low. a capacity of zero gives no characters.
//   cfg_we_i writes the capacity from cfg_wdata_i; write it only while idle.
//   flow: a two-entry job queue lets the front end take up to two items
//   while the back end works; the back end finishes one item before it takes
//   the next. per item it first converts binary to bcd (decimal only, four
//   bits per cycle), then generates the digits, then any padding, prefix or
//   sign characters, and then outputs the characters.
//   when the receiver stalls, the output register holds its character and
//   the back end waits; the queue fills and then in_stall_o rises.
//   reset empties the queue and output register and sets the capacity to 64.
module integer_to_ascii_radix_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itoa_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [itoa_pkg::VAL_W-1:0]     value_i,
  input  logic                           is_signed_i,
  input  logic [2:0]                     kind_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     character_o,
  output logic                           last_o
);

  logic [itoa_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [itoa_pkg::LEN_W-1:0] cap_eff;
  logic                       q_full;
  logic                       q_push;
  logic                       q_empty;
  logic                       q_pop;
  itoa_pkg::job_t             job_in;
  itoa_pkg::job_t             job_out;

  assign cap_d   = cfg_we_i ? cfg_wdata_i : cap_q;
  assign cap_eff = (cap_q > itoa_pkg::CAP_W'(itoa_pkg::MAX_CHARS))
                 ? itoa_pkg::LEN_W'(itoa_pkg::MAX_CHARS)
                 : itoa_pkg::LEN_W'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= itoa_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  itoa_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .is_signed_i (is_signed_i),
    .kind_i      (kind_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (job_in)
  );

  itoa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (job_out),
    .q_pop_o     (q_pop),
    .cap_i       (cap_eff),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
